// ===== hdl/gsrl_pkg.sv =====
`default_nettype none
package gsrl_pkg;

  localparam logic [31:0] ONE_Q24   = 32'h0100_0000;
  localparam logic [16:0] ONE_Q16   = 17'h1_0000;
  localparam logic [31:0] LN2PI_Q16 = 32'd120447;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [40:0] RATIO_CAP = 41'h100_0000_0000;
  localparam logic [31:0] LL_MIN    = 32'h8000_0000;
  localparam logic [31:0] LL_MAX    = 32'h7FFF_FFFF;

  localparam int unsigned DivNumW  = 80;
  localparam int unsigned DivDenW  = 64;
  localparam int unsigned DivCntW  = $clog2(DivNumW);
  localparam int unsigned LogFracW = 24;

  typedef enum logic [1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_MEAN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dmag;
    logic [31:0] eps;
    logic [31:0] tau;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

endpackage
`default_nettype wire

// ===== hdl/gsrl_front.sv =====
`default_nettype none
module gsrl_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic                start_i,
  input  wire logic signed [31:0]  ret_i,
  input  wire logic [31:0]         eps_i,
  input  wire logic [31:0]         tau_i,
  input  wire logic signed [31:0]  mean_i,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output gsrl_pkg::item_t          item_o
);

  gsrl_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_push, do_pop;
  logic [32:0]     diff;
  logic [32:0]     dabs;
  gsrl_pkg::item_t new_item;

  // distance of the return from the mean
  assign diff = {ret_i[31], ret_i} - {mean_i[31], mean_i};
  assign dabs = diff[32] ? (33'd0 - diff) : diff;

  always_comb begin
    new_item.start = start_i;
    new_item.dmag  = dabs[31:0];
    new_item.eps   = eps_i;
    new_item.tau   = tau_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gsrl_div.sv =====
`default_nettype none
module gsrl_div (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire gsrl_pkg::div_req_t                    req_i,
  output logic                                       busy_o,
  output logic [gsrl_pkg::DivNumW-1:0]               quot_o
);

  logic                                busy_q;
  logic [gsrl_pkg::DivCntW-1:0]        cnt_q;
  logic [gsrl_pkg::DivNumW-1:0]        num_q;
  logic [gsrl_pkg::DivDenW-1:0]        rem_q;
  logic [gsrl_pkg::DivDenW-1:0]        den_q;
  logic [gsrl_pkg::DivDenW:0]          rem2;
  logic [gsrl_pkg::DivDenW:0]          sub;
  logic                                ge;

  // restoring division, one quotient bit per cycle
  assign rem2 = {rem_q, num_q[gsrl_pkg::DivNumW-1]};
  assign ge   = (rem2 >= {1'b0, den_q});
  assign sub  = rem2 - {1'b0, den_q};

  assign busy_o = busy_q;
  assign quot_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == gsrl_pkg::DivCntW'(gsrl_pkg::DivNumW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[gsrl_pkg::DivNumW-2:0], ge};
      rem_q <= ge ? sub[gsrl_pkg::DivDenW-1:0] : rem2[gsrl_pkg::DivDenW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gsrl_log.sv =====
`default_nettype none
module gsrl_log (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [63:0]         v_i,
  output logic                     busy_o,
  output logic signed [24:0]       ln_o
);

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_SQR,
    L_MUL
  } lstate_e;

  lstate_e                           state_q;
  logic [63:0]                       vn_q;
  logic [5:0]                        p_q;
  logic [31:0]                       m_q;
  logic [gsrl_pkg::LogFracW-1:0]     frac_q;
  logic [4:0]                        cnt_q;
  logic signed [24:0]                ln_q;
  logic [63:0]                       sq;
  logic [32:0]                       t;
  logic [7:0]                        expo;
  logic [31:0]                       l2;
  logic signed [64:0]                prod;

  assign sq   = m_q * m_q;
  assign t    = sq[63:31];
  assign expo = {2'b00, p_q} - 8'd48;
  assign l2   = {expo, frac_q};
  assign prod = $signed(l2) * $signed({1'b0, gsrl_pkg::LN2_Q32});

  assign busy_o = (state_q != L_IDLE);
  assign ln_o   = ln_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      vn_q    <= '0;
      p_q     <= '0;
      m_q     <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
      ln_q    <= '0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            vn_q    <= v_i;
            p_q     <= 6'd63;
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (vn_q[63:56] == 8'd0) begin
            vn_q <= {vn_q[55:0], 8'd0};
            p_q  <= p_q - 6'd8;
          end else if (!vn_q[63]) begin
            vn_q <= {vn_q[62:0], 1'b0};
            p_q  <= p_q - 6'd1;
          end else begin
            m_q     <= vn_q[63:32];
            frac_q  <= '0;
            cnt_q   <= '0;
            state_q <= L_SQR;
          end
        end
        L_SQR: begin
          m_q    <= t[32] ? t[32:1] : t[31:0];
          frac_q <= {frac_q[gsrl_pkg::LogFracW-2:0], t[32]};
          cnt_q  <= cnt_q + 5'd1;
          if (cnt_q == 5'(gsrl_pkg::LogFracW - 1)) begin
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          ln_q    <= prod[64:40];
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gsrl_back.sv =====
`default_nettype none
module gsrl_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_empty_i,
  input  wire gsrl_pkg::item_t     item_i,
  output logic                     q_pop_o,
  input  wire logic [16:0]         alpha_i,
  input  wire logic [16:0]         beta_i,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output logic [31:0]              ll_o,
  output logic [31:0]              g_o,
  output logic                     err_o
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLASS,
    B_RWAIT,
    B_ARCH,
    B_VMUL,
    B_CHK,
    B_QWAIT,
    B_OUT
  } bstate_e;

  bstate_e                           state_q;
  gsrl_pkg::item_t                   it_q;
  logic [63:0]                       e2_q;
  logic [32:0]                       pers_q;
  logic [40:0]                       ratio_q;
  logic [31:0]                       g_q;
  logic [63:0]                       v_q;
  logic [63:0]                       dd_q;
  logic                              err_q;
  logic [31:0]                       lres_q;
  logic [31:0]                       prev_eps_q, prev_tau_q, prev_g_q;
  logic                              out_vld_q;
  logic [31:0]                       out_ll_q, out_g_q;
  logic                              out_err_q;

  logic [16:0]                       a, b;
  logic [31:0]                       emag;
  logic [63:0]                       e2;
  logic [48:0]                       bg;
  logic [57:0]                       ar;
  logic signed [43:0]                base, sum;
  logic [63:0]                       v, dd;
  gsrl_pkg::div_req_t                div_req;
  logic                              div_busy;
  logic [gsrl_pkg::DivNumW-1:0]      quot;
  logic                              log_start, log_busy;
  logic signed [24:0]                ln;
  logic [32:0]                       qint;
  logic signed [50:0]                s, half;
  logic [31:0]                       ll_sat;

  assign a = (alpha_i > gsrl_pkg::ONE_Q16) ? gsrl_pkg::ONE_Q16 : alpha_i;
  assign b = (beta_i > gsrl_pkg::ONE_Q16) ? gsrl_pkg::ONE_Q16 : beta_i;

  assign emag = prev_eps_q[31] ? (32'd0 - prev_eps_q) : prev_eps_q;
  assign e2   = emag * emag;
  assign bg   = b * prev_g_q;
  assign ar   = a * ratio_q;
  assign base = ($signed({27'd0, gsrl_pkg::ONE_Q16}) - $signed({27'd0, a})
                - $signed({27'd0, b})) <<< 8;
  assign sum  = base + $signed({2'b00, ar[57:16]}) + $signed({11'd0, pers_q});
  assign v    = g_q * it_q.tau;
  assign dd   = it_q.dmag * it_q.dmag;

  assign q_pop_o = (state_q == B_IDLE) && !q_empty_i;

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {16'd0, e2_q};
    div_req.den   = {32'd0, prev_tau_q};
    if (state_q == B_CLASS) begin
      div_req.start = !it_q.start && (prev_tau_q != 32'd0);
    end else if (state_q == B_CHK) begin
      div_req.start = (v_q != 64'd0);
      div_req.num   = {dd_q, 16'd0};
      div_req.den   = v_q;
    end
  end

  assign log_start = (state_q == B_CHK) && (v_q != 64'd0);

  gsrl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  gsrl_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .v_i     (v_q),
    .busy_o  (log_busy),
    .ln_o    (ln)
  );

  // quadratic term, integer part capped at 2^32
  assign qint = (quot[79:16] > 64'hFFFF_FFFF) ? 33'h1_0000_0000 : {1'b0, quot[47:16]};
  assign s    = $signed({19'd0, gsrl_pkg::LN2PI_Q16}) + 51'(ln)
                + $signed({2'b00, qint, quot[15:0]});
  assign half = (51'sd0 - s) >>> 1;

  always_comb begin
    if (half > $signed({19'd0, gsrl_pkg::LL_MAX})) begin
      ll_sat = gsrl_pkg::LL_MAX;
    end else if (half < -$signed({19'd0, gsrl_pkg::LL_MIN})) begin
      ll_sat = gsrl_pkg::LL_MIN;
    end else begin
      ll_sat = half[31:0];
    end
  end

  assign empty_o = !out_vld_q;
  assign ll_o    = out_ll_q;
  assign g_o     = out_g_q;
  assign err_o   = out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      it_q       <= '0;
      e2_q       <= '0;
      pers_q     <= '0;
      ratio_q    <= '0;
      g_q        <= '0;
      v_q        <= '0;
      dd_q       <= '0;
      err_q      <= 1'b0;
      lres_q     <= '0;
      prev_eps_q <= '0;
      prev_tau_q <= '0;
      prev_g_q   <= gsrl_pkg::ONE_Q24;
      out_vld_q  <= 1'b0;
      out_ll_q   <= '0;
      out_g_q    <= '0;
      out_err_q  <= 1'b0;
    end else begin
      if (pop_i && out_vld_q && (state_q != B_OUT)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            it_q    <= item_i;
            e2_q    <= e2;
            pers_q  <= bg[48:16];
            state_q <= B_CLASS;
          end
        end
        B_CLASS: begin
          if (it_q.start) begin
            g_q     <= gsrl_pkg::ONE_Q24;
            state_q <= B_VMUL;
          end else if (prev_tau_q == 32'd0) begin
            g_q     <= pers_q[32] ? 32'hFFFF_FFFF : pers_q[31:0];
            state_q <= B_VMUL;
          end else begin
            state_q <= B_RWAIT;
          end
        end
        B_RWAIT: begin
          if (!div_busy) begin
            ratio_q <= (quot > 80'(gsrl_pkg::RATIO_CAP)) ? gsrl_pkg::RATIO_CAP : quot[40:0];
            state_q <= B_ARCH;
          end
        end
        B_ARCH: begin
          if (sum[43]) begin
            g_q <= 32'd0;
          end else if (sum > 44'sh0_FFFF_FFFF) begin
            g_q <= 32'hFFFF_FFFF;
          end else begin
            g_q <= sum[31:0];
          end
          state_q <= B_VMUL;
        end
        B_VMUL: begin
          v_q     <= v;
          dd_q    <= dd;
          state_q <= B_CHK;
        end
        B_CHK: begin
          if (v_q == 64'd0) begin
            err_q   <= 1'b1;
            lres_q  <= gsrl_pkg::LL_MIN;
            state_q <= B_OUT;
          end else begin
            err_q   <= 1'b0;
            state_q <= B_QWAIT;
          end
        end
        B_QWAIT: begin
          if (!div_busy && !log_busy) begin
            lres_q  <= ll_sat;
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_vld_q || pop_i) begin
            out_vld_q  <= 1'b1;
            out_ll_q   <= lres_q;
            out_g_q    <= g_q;
            out_err_q  <= err_q;
            prev_eps_q <= it_q.eps;
            prev_tau_q <= it_q.tau;
            prev_g_q   <= g_q;
            state_q    <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/garch_short_run_loglik.sv =====
// GARCH short-run factor and per-observation Gaussian log-likelihood. Each request
// carries one observation (return Q7.24, residual Q7.24, long-run variance Q8.24)
// and yields one result: the log-likelihood in Q15.16, the short-run factor g in
// Q8.24 and a domain flag when g*tau is zero. In the back end an observation runs
// two 80-bit divisions one after the other on the shared restoring divider, and
// the logarithm runs next to the second one. A series start, or a previous tau of
// zero, skips the first division; a zero g*tau skips the second and the logarithm.
// A two-entry input queue and a one-entry result register decouple both sides.
`default_nettype none
module garch_short_run_loglik (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [31:0]         cfg_wdata_i,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                series_start_i,
  input  wire logic signed [31:0]  daily_return_i,
  input  wire logic signed [31:0]  residual_i,
  input  wire logic [31:0]         long_run_variance_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [31:0]       log_likelihood_o,
  output logic [31:0]              short_run_component_o,
  output logic                     domain_error_o
);

  logic [16:0]         alpha_q, beta_q;
  logic signed [31:0]  mean_q;
  logic                q_empty, q_pop;
  gsrl_pkg::item_t     item;
  logic [31:0]         ll;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
      beta_q  <= '0;
      mean_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gsrl_pkg::CFG_ALPHA: alpha_q <= cfg_wdata_i[16:0];
        gsrl_pkg::CFG_BETA:  beta_q  <= cfg_wdata_i[16:0];
        gsrl_pkg::CFG_MEAN:  mean_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gsrl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .start_i (series_start_i),
    .ret_i   (daily_return_i),
    .eps_i   (residual_i),
    .tau_i   (long_run_variance_i),
    .mean_i  (mean_q),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (item)
  );

  gsrl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .item_i    (item),
    .q_pop_o   (q_pop),
    .alpha_i   (alpha_q),
    .beta_i    (beta_q),
    .pop_i     (pop),
    .empty_o   (empty),
    .ll_o      (ll),
    .g_o       (short_run_component_o),
    .err_o     (domain_error_o)
  );

  assign log_likelihood_o = $signed(ll);

`ifndef NO_ASSERTIONS
  a_err_ll_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && domain_error_o |-> ll == gsrl_pkg::LL_MIN)
    else $error("domain error without saturated likelihood");

  a_zero_g_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && short_run_component_o == 32'd0 |-> domain_error_o)
    else $error("zero short-run factor without domain error");
`endif

endmodule
`default_nettype wire
